// ----- hdl/stq_pkg.sv -----
// shared types and codes of the sorted timer queue
`default_nettype none

package stq_pkg;

    // fixed field widths of the request and result
    localparam int ID_BITS    = 4;
    localparam int FIELD_TIME = 48;

    // most expiries popped by one tick
    localparam int MAX_POPS = 16;
    localparam int CNT_BITS = 4;

    // operation codes
    localparam logic [2:0] OP_ADD     = 3'd0;
    localparam logic [2:0] OP_DELETE  = 3'd1;
    localparam logic [2:0] OP_DEFER   = 3'd2;
    localparam logic [2:0] OP_TICK    = 3'd3;
    localparam logic [2:0] OP_HANDLER = 3'd4;

    // result kinds
    localparam logic [1:0] EV_DONE    = 2'd0;
    localparam logic [1:0] EV_EXPIRED = 2'd1;
    localparam logic [1:0] EV_RUNS    = 2'd2;
    localparam logic [1:0] EV_SKIPPED = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_NOT_PENDING = 2'd1;
    localparam logic [1:0] ST_DEFERRED    = 2'd2;

    typedef struct packed {
        logic [2:0]            operation;
        logic [ID_BITS-1:0]    timer_id;
        logic [FIELD_TIME-1:0] expiry_time;
        logic [FIELD_TIME-1:0] now_time;
    } request_t;

    typedef struct packed {
        logic [1:0]         event_kind;
        logic [ID_BITS-1:0] result_id;
        logic [1:0]         status;
        logic               became_head;
        logic               last_result;
    } result_t;

    // command broadcast to every cell of the chain
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_REMOVE,
        CELL_INSERT,
        CELL_POP
    } cell_op_t;

    typedef struct packed {
        cell_op_t           op;
        logic [ID_BITS-1:0] id;
    } cell_cmd_t;

endpackage

`default_nettype wire

// ----- hdl/sorted_timer_queue_unit.sv -----
// sorted timer queue: top level with control sequencer and cell chain
// Usage:
//   request channel (request_valid / request_stall / request) carries one
//   operation: add, delete, deferred delete, tick or handler run.
//   result channel (result_valid / result_stall / result) returns the
//   results; the final result of each request has last_result set.
// Timing:
//   delete, deferred delete, handler run, idle tick: one result, registered
//   in the cycle after the request is taken; a new request every cycle
//   while results are not stalled. add: removal along the chain, then
//   ordered insertion. tick: one expiry per cycle from the head cell while
//   not stalled; at most 16 pops per tick, the rest stay queued.
// The single output register decides pacing: a request is taken only while
// the sequencer is idle and the output register is empty or being drained.
// Reset empties the queue and clears all fired and stopped flags; no
// clearing pass is needed. A stalled result holds, and the sequencer
// waits with it without losing work.
`default_nettype none

module sorted_timer_queue_unit #(
    parameter int TIMER_SLOTS = 16,
    parameter int TIME_BITS   = 48
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              request_valid,
    output logic                   request_stall,
    input  wire stq_pkg::request_t request,
    output logic                   result_valid,
    input  wire logic              result_stall,
    output stq_pkg::result_t       result
);

    localparam int         IDX_W   = $clog2(TIMER_SLOTS);
    localparam logic [6:0] SLOTS_C = 7'(TIMER_SLOTS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ADD,
        S_TICK
    } state_t;

    state_t                         state_reg, state_next;
    logic                           rv_reg, rv_next;
    stq_pkg::result_t               res_reg, res_next;
    logic [stq_pkg::CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic [stq_pkg::ID_BITS-1:0]    key_id_reg, key_id_next;
    logic [TIME_BITS-1:0]           exp_reg, exp_next;
    logic [TIME_BITS-1:0]           now_reg, now_next;
    logic [TIMER_SLOTS-1:0]         fired_reg, fired_next;
    logic [TIMER_SLOTS-1:0]         stopped_reg, stopped_next;

    // chain wiring
    stq_pkg::cell_cmd_t             cmd;
    logic [TIME_BITS-1:0]           key_time;
    logic [TIMER_SLOTS-1:0]         cell_valid;
    logic [TIMER_SLOTS-1:0]         cell_le;
    logic [stq_pkg::ID_BITS-1:0]    cell_id [TIMER_SLOTS];
    logic [TIME_BITS-1:0]           cell_time [TIMER_SLOTS];
    logic [TIMER_SLOTS:0]           shift_chain;

    // request decode
    logic                           out_free;
    logic                           accept;
    logic                           bad_slot;
    logic [IDX_W-1:0]               req_idx;
    logic [IDX_W-1:0]               head_idx;
    logic [63:0]                    exp_wide;
    logic [63:0]                    now_wide;
    logic [TIME_BITS-1:0]           exp_in;
    logic [TIME_BITS-1:0]           now_in;
    logic                           last_pop;

    assign out_free      = !rv_reg || !result_stall;
    assign request_stall = !((state_reg == S_IDLE) && out_free);
    assign accept        = request_valid && !request_stall;

    // times are kept modulo 2^TIME_BITS
    assign exp_wide = 64'(request.expiry_time);
    assign now_wide = 64'(request.now_time);
    assign exp_in   = exp_wide[TIME_BITS-1:0];
    assign now_in   = now_wide[TIME_BITS-1:0];

    assign bad_slot = ({3'b000, request.timer_id} >= SLOTS_C);
    assign req_idx  = IDX_W'(request.timer_id);
    assign head_idx = IDX_W'(cell_id[0]);

    // a pop is the last one when the next head is not due or the cap is hit
    assign last_pop = !cell_le[1] ||
                      (cnt_reg == stq_pkg::CNT_BITS'(stq_pkg::MAX_POPS - 1));

    assign shift_chain[0] = (cmd.op == stq_pkg::CELL_POP);

    genvar gi;
    generate
        for (gi = 0; gi < TIMER_SLOTS; gi++)
        begin : g_cell
            logic                        l_valid;
            logic [stq_pkg::ID_BITS-1:0] l_id;
            logic [TIME_BITS-1:0]        l_time;
            logic                        l_le;
            logic                        r_valid;
            logic [stq_pkg::ID_BITS-1:0] r_id;
            logic [TIME_BITS-1:0]        r_time;

            if (gi == 0)
            begin : g_head
                // head cell: a new entry lands here when no entry is earlier or equal
                assign l_valid = 1'b0;
                assign l_id    = '0;
                assign l_time  = '0;
                assign l_le    = 1'b1;
            end
            else
            begin : g_mid
                assign l_valid = cell_valid[gi-1];
                assign l_id    = cell_id[gi-1];
                assign l_time  = cell_time[gi-1];
                assign l_le    = cell_le[gi-1];
            end

            if (gi == TIMER_SLOTS - 1)
            begin : g_tail
                assign r_valid = 1'b0;
                assign r_id    = '0;
                assign r_time  = '0;
            end
            else
            begin : g_body
                assign r_valid = cell_valid[gi+1];
                assign r_id    = cell_id[gi+1];
                assign r_time  = cell_time[gi+1];
            end

            stq_cell #(
                .TIME_BITS (TIME_BITS)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .cmd         (cmd),
                .key_time    (key_time),
                .left_valid  (l_valid),
                .left_id     (l_id),
                .left_time   (l_time),
                .left_le     (l_le),
                .right_valid (r_valid),
                .right_id    (r_id),
                .right_time  (r_time),
                .shift_in    (shift_chain[gi]),
                .entry_valid (cell_valid[gi]),
                .entry_id    (cell_id[gi]),
                .entry_time  (cell_time[gi]),
                .le          (cell_le[gi]),
                .shift_out   (shift_chain[gi+1])
            );
        end
    endgenerate

    // chain command and compare key for this cycle
    always_comb
    begin
        cmd.op   = stq_pkg::CELL_HOLD;
        cmd.id   = request.timer_id;
        key_time = now_in;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && !bad_slot)
                begin
                    case (request.operation)
                        stq_pkg::OP_ADD, stq_pkg::OP_DELETE:
                        begin
                            // drop any queued copy of the timer
                            cmd.op = stq_pkg::CELL_REMOVE;
                        end
                        stq_pkg::OP_DEFER:
                        begin
                            if (!fired_reg[req_idx])
                            begin
                                cmd.op = stq_pkg::CELL_REMOVE;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_ADD:
            begin
                cmd.id   = key_id_reg;
                key_time = exp_reg;
                if (out_free)
                begin
                    cmd.op = stq_pkg::CELL_INSERT;
                end
            end
            S_TICK:
            begin
                key_time = now_reg;
                if (out_free)
                begin
                    cmd.op = stq_pkg::CELL_POP;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next   = state_reg;
        rv_next      = rv_reg;
        res_next     = res_reg;
        cnt_next     = cnt_reg;
        key_id_next  = key_id_reg;
        exp_next     = exp_reg;
        now_next     = now_reg;
        fired_next   = fired_reg;
        stopped_next = stopped_reg;

        // result taken downstream
        if (rv_reg && !result_stall)
        begin
            rv_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    // default: one done result for this timer
                    rv_next  = 1'b1;
                    res_next = '{event_kind:  stq_pkg::EV_DONE,
                                 result_id:   request.timer_id,
                                 status:      stq_pkg::ST_OK,
                                 became_head: 1'b0,
                                 last_result: 1'b1};
                    case (request.operation)
                        stq_pkg::OP_TICK:
                        begin
                            // head due: pop from next cycle on
                            if (cell_le[0])
                            begin
                                rv_next    = 1'b0;
                                state_next = S_TICK;
                                now_next   = now_in;
                                cnt_next   = '0;
                            end
                        end
                        stq_pkg::OP_ADD:
                        begin
                            if (bad_slot)
                            begin
                                res_next.status = stq_pkg::ST_NOT_PENDING;
                            end
                            else
                            begin
                                // drop any queued copy now, insert next cycle
                                rv_next               = 1'b0;
                                stopped_next[req_idx] = 1'b0;
                                key_id_next           = request.timer_id;
                                exp_next              = exp_in;
                                state_next            = S_ADD;
                            end
                        end
                        stq_pkg::OP_DELETE:
                        begin
                            if (bad_slot)
                            begin
                                res_next.status = stq_pkg::ST_NOT_PENDING;
                            end
                            else
                            begin
                                stopped_next[req_idx] = 1'b1;
                                // chain end carries the found flag
                                if (!shift_chain[TIMER_SLOTS])
                                begin
                                    res_next.status = stq_pkg::ST_NOT_PENDING;
                                end
                            end
                        end
                        stq_pkg::OP_DEFER:
                        begin
                            if (bad_slot)
                            begin
                                res_next.status = stq_pkg::ST_NOT_PENDING;
                            end
                            else if (fired_reg[req_idx])
                            begin
                                res_next.status = stq_pkg::ST_DEFERRED;
                            end
                        end
                        stq_pkg::OP_HANDLER:
                        begin
                            if (bad_slot)
                            begin
                                res_next.status = stq_pkg::ST_NOT_PENDING;
                            end
                            else if (stopped_reg[req_idx])
                            begin
                                res_next.event_kind = stq_pkg::EV_SKIPPED;
                            end
                            else
                            begin
                                fired_next[req_idx] = 1'b0;
                                res_next.event_kind = stq_pkg::EV_RUNS;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_ADD:
            begin
                if (out_free)
                begin
                    rv_next    = 1'b1;
                    res_next   = '{event_kind:  stq_pkg::EV_DONE,
                                   result_id:   key_id_reg,
                                   status:      stq_pkg::ST_OK,
                                   became_head: !cell_le[0],
                                   last_result: 1'b1};
                    state_next = S_IDLE;
                end
            end
            S_TICK:
            begin
                if (out_free)
                begin
                    fired_next[head_idx] = 1'b1;
                    rv_next              = 1'b1;
                    res_next             = '{event_kind:  stq_pkg::EV_EXPIRED,
                                             result_id:   cell_id[0],
                                             status:      stq_pkg::ST_OK,
                                             became_head: 1'b0,
                                             last_result: last_pop};
                    cnt_next             = cnt_reg + 1'b1;
                    if (last_pop)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            rv_reg      <= 1'b0;
            res_reg     <= '0;
            cnt_reg     <= '0;
            key_id_reg  <= '0;
            exp_reg     <= '0;
            now_reg     <= '0;
            fired_reg   <= '0;
            stopped_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            rv_reg      <= rv_next;
            res_reg     <= res_next;
            cnt_reg     <= cnt_next;
            key_id_reg  <= key_id_next;
            exp_reg     <= exp_next;
            now_reg     <= now_next;
            fired_reg   <= fired_next;
            stopped_reg <= stopped_next;
        end
    end

    assign result_valid = rv_reg;
    assign result       = res_reg;

    // occupied cells always form a prefix of the chain
    a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        (cell_valid & (cell_valid + 1'b1)) == '0)
        else $error("queue entries do not form a prefix");

    // while popping, the head cell is always due
    a_tick_head_due: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TICK) |-> (cell_valid[0] && cell_le[0]))
        else $error("tick pops a timer that is not due");

    // only expiries are followed by further results of the same request
    a_multi_only_expired: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.last_result) |->
            (result.event_kind == stq_pkg::EV_EXPIRED))
        else $error("non-final result that is not an expiry");

    // an add always yields its result in the cycle after the ordered insertion
    a_add_two_cycles: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ADD && out_free) |=> (state_reg == S_IDLE && result_valid))
        else $error("add did not complete after insertion");

endmodule

`default_nettype wire

// ----- hdl/stq_cell.sv -----
// one entry of the sorted queue, trading contents with its neighbors
`default_nettype none

module stq_cell #(
    parameter int TIME_BITS = 48
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire stq_pkg::cell_cmd_t          cmd,
    input  wire logic [TIME_BITS-1:0]        key_time,
    input  wire logic                        left_valid,
    input  wire logic [stq_pkg::ID_BITS-1:0] left_id,
    input  wire logic [TIME_BITS-1:0]        left_time,
    input  wire logic                        left_le,
    input  wire logic                        right_valid,
    input  wire logic [stq_pkg::ID_BITS-1:0] right_id,
    input  wire logic [TIME_BITS-1:0]        right_time,
    input  wire logic                        shift_in,
    output logic                             entry_valid,
    output logic [stq_pkg::ID_BITS-1:0]      entry_id,
    output logic [TIME_BITS-1:0]             entry_time,
    output logic                             le,
    output logic                             shift_out
);

    logic                        valid_reg, valid_next;
    logic [stq_pkg::ID_BITS-1:0] id_reg, id_next;
    logic [TIME_BITS-1:0]        time_reg, time_next;
    logic                        match;

    assign match     = valid_reg && (id_reg == cmd.id);
    assign le        = valid_reg && (time_reg <= key_time);
    assign shift_out = shift_in || ((cmd.op == stq_pkg::CELL_REMOVE) && match);

    always_comb
    begin
        valid_next = valid_reg;
        id_next    = id_reg;
        time_next  = time_reg;
        case (cmd.op)
            stq_pkg::CELL_REMOVE, stq_pkg::CELL_POP:
            begin
                // close the gap: take the right neighbor's entry
                if (shift_out)
                begin
                    valid_next = right_valid;
                    id_next    = right_id;
                    time_next  = right_time;
                end
            end
            stq_pkg::CELL_INSERT:
            begin
                if (!le)
                begin
                    if (left_le)
                    begin
                        valid_next = 1'b1;
                        id_next    = cmd.id;
                        time_next  = key_time;
                    end
                    else
                    begin
                        valid_next = left_valid;
                        id_next    = left_id;
                        time_next  = left_time;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg   <= id_next;
        time_reg <= time_next;
    end

    assign entry_valid = valid_reg;
    assign entry_id    = id_reg;
    assign entry_time  = time_reg;

endmodule

`default_nettype wire
